/* design/pppc_pkg.sv */
// Package for the pump pressure protection controller: widths, constants, register map, types.
`timescale 1ns / 1ps

package pppc_pkg;

	// Field widths.
	localparam int unsigned QW      = 16;
	localparam int unsigned MSW     = 10;
	localparam int unsigned LEVELW  = 8;
	localparam int unsigned S_DATAW = 96;
	localparam int unsigned S_USERW = 4;
	localparam int unsigned M_DATAW = 24;
	localparam int unsigned M_USERW = 2;
	localparam int unsigned ADDRW   = 4;
	localparam int unsigned APBW    = 32;

	// Register indexes, taken from paddr[3:2].
	localparam logic [1:0] REG_PRESSURE_ON  = 2'd0;
	localparam logic [1:0] REG_PRESSURE_OFF = 2'd1;
	localparam logic [1:0] REG_CURRENT_LIM  = 2'd2;
	localparam logic [1:0] REG_IMBAL_LIM    = 2'd3;

	// Register reset values, unsigned Q8.8.
	localparam logic [QW-1:0] PRESSURE_ON_RST  = 16'd640;
	localparam logic [QW-1:0] PRESSURE_OFF_RST = 16'd896;
	localparam logic [QW-1:0] CURRENT_LIM_RST  = 16'd3840;
	localparam logic [QW-1:0] IMBAL_LIM_RST    = 16'd768;

	// Fixed pressure window of 1.0 to 5.0 bar in Q8.8.
	localparam logic [QW-1:0] PRESSURE_LOW  = 16'd256;
	localparam logic [QW-1:0] PRESSURE_HIGH = 16'd1280;

	// Blink timing in milliseconds and light levels.
	localparam logic [MSW-1:0]    ERROR_BLINK_MS = 10'd500;
	localparam logic [MSW-1:0]    IDLE_BLINK_MS  = 10'd50;
	localparam logic [LEVELW-1:0] LEVEL_FULL     = 8'd255;
	localparam logic [LEVELW-1:0] LEVEL_DIM      = 8'd64;
	localparam logic [LEVELW-1:0] LEVEL_OFF      = 8'd0;

	// Bit positions in the tuser words.
	localparam int unsigned SU_MAIN   = 0;
	localparam int unsigned SU_MANUAL = 1;
	localparam int unsigned SU_MANRUN = 2;
	localparam int unsigned SU_LIGHTS = 3;
	localparam int unsigned MU_MOTOR  = 0;
	localparam int unsigned MU_FAULT  = 1;

	// One control tick as held in the input register.
	typedef struct packed {
		logic [QW-1:0]  pressure;
		logic [QW-1:0]  total_current;
		logic [QW-1:0]  phase1_current;
		logic [QW-1:0]  phase2_current;
		logic [QW-1:0]  phase3_current;
		logic [MSW-1:0] ms_phase;
		logic           main_switch_on;
		logic           manual_mode;
		logic           manual_run;
		logic           lights_enabled;
	} tick_t;

	// One result as held in the output register.
	typedef struct packed {
		logic              motor_run;
		logic              fault;
		logic [LEVELW-1:0] red_level;
		logic [LEVELW-1:0] green_level;
		logic [LEVELW-1:0] blue_level;
	} result_t;

	// Spread between the largest and the smallest of three phase currents.
	function automatic logic [QW-1:0] phase_spread(input logic [QW-1:0] a,
			input logic [QW-1:0] b, input logic [QW-1:0] c);
		logic [QW-1:0] hi;
		logic [QW-1:0] lo;
		hi = (a > b) ? a : b;
		hi = (hi > c) ? hi : c;
		lo = (a < b) ? a : b;
		lo = (lo < c) ? lo : c;
		return hi - lo;
	endfunction

endpackage

/* design/pump_pressure_protection_controller_top.sv */
// Top level of the pump pressure protection controller.
`timescale 1ns / 1ps

// Usage: each beat on the s_ channel is one control tick carrying pressure, the total
// and three phase currents (unsigned Q8.8), the millisecond phase and four switch flags.
// Each tick gives exactly one beat on the m_ channel: motor drive, latched fault flag
// and the red, green and blue light levels. Thresholds sit in four 16-bit registers on
// the APB port at byte addresses 0, 4, 8 and 12; the user must see that they are written
// only while no tick is in flight, as the block itself does not enforce it. A tick is
// captured in the input register, evaluated against the motor and fault state in one
// pass of compare logic, and lands in the output register, which drives m_tvalid.
// Throughput is one tick per cycle while the receiver does not stall.
// Reset clears the motor and fault state, restores the register defaults and empties
// both stages. When the receiver stalls the output beat holds; the input register still
// takes one more tick, after which s_tready falls until the output drains.
module pump_pressure_protection_controller_top (
	input  logic                         clk,
	input  logic                         arst_n,
	// Input stream.
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// tdata: pressure, total_current, phase1_current, phase2_current, phase3_current,
	// ms_phase, zero fill (bits 95:90)
	input  logic [pppc_pkg::S_DATAW-1:0] s_tdata,
	// tuser: main_switch_on, manual_mode, manual_run, lights_enabled
	input  logic [pppc_pkg::S_USERW-1:0] s_tuser,
	// Output stream.
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// tdata: red_level, green_level, blue_level
	output logic [pppc_pkg::M_DATAW-1:0] m_tdata,
	// tuser: motor_run, fault
	output logic [pppc_pkg::M_USERW-1:0] m_tuser,
	// Configuration port.
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [pppc_pkg::ADDRW-1:0]   paddr,
	input  logic [pppc_pkg::APBW-1:0]    pwdata,
	output logic [pppc_pkg::APBW-1:0]    prdata,
	output logic                         pready
);

	logic [pppc_pkg::QW-1:0] pressure_on_q;
	logic [pppc_pkg::QW-1:0] pressure_off_q;
	logic [pppc_pkg::QW-1:0] current_lim_q;
	logic [pppc_pkg::QW-1:0] imbal_lim_q;
	logic [1:0]              reg_idx;
	logic                    cfg_wr;

	pppc_pkg::tick_t   tick_s1;
	logic              valid_s1;
	pppc_pkg::result_t res_q;
	pppc_pkg::result_t res_d;
	logic              out_valid_q;
	logic              motor_q;
	logic              error_q;
	logic              advance;
	logic              take;

	logic              err_next;
	logic              motor_after_err;
	logic              motor_next;
	logic [pppc_pkg::LEVELW-1:0] red_d;
	logic [pppc_pkg::LEVELW-1:0] green_d;
	logic [pppc_pkg::LEVELW-1:0] blue_d;

	// Configuration registers.
	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pressure_on_q  <= pppc_pkg::PRESSURE_ON_RST;
			pressure_off_q <= pppc_pkg::PRESSURE_OFF_RST;
			current_lim_q  <= pppc_pkg::CURRENT_LIM_RST;
			imbal_lim_q    <= pppc_pkg::IMBAL_LIM_RST;
		end else if (cfg_wr) begin
			case (reg_idx)
				pppc_pkg::REG_PRESSURE_ON:  pressure_on_q  <= pwdata[pppc_pkg::QW-1:0];
				pppc_pkg::REG_PRESSURE_OFF: pressure_off_q <= pwdata[pppc_pkg::QW-1:0];
				pppc_pkg::REG_CURRENT_LIM:  current_lim_q  <= pwdata[pppc_pkg::QW-1:0];
				pppc_pkg::REG_IMBAL_LIM:    imbal_lim_q    <= pwdata[pppc_pkg::QW-1:0];
				default: begin
				end
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		prdata = '0;
		case (reg_idx)
			pppc_pkg::REG_PRESSURE_ON:  prdata[pppc_pkg::QW-1:0] = pressure_on_q;
			pppc_pkg::REG_PRESSURE_OFF: prdata[pppc_pkg::QW-1:0] = pressure_off_q;
			pppc_pkg::REG_CURRENT_LIM:  prdata[pppc_pkg::QW-1:0] = current_lim_q;
			pppc_pkg::REG_IMBAL_LIM:    prdata[pppc_pkg::QW-1:0] = imbal_lim_q;
			default:                    prdata = '0;
		endcase
	end

	// Handshake: stage one moves on when the output register is free or being drained.
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign take     = s_tvalid && s_tready;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			tick_s1.pressure       <= s_tdata[15:0];
			tick_s1.total_current  <= s_tdata[31:16];
			tick_s1.phase1_current <= s_tdata[47:32];
			tick_s1.phase2_current <= s_tdata[63:48];
			tick_s1.phase3_current <= s_tdata[79:64];
			tick_s1.ms_phase       <= s_tdata[89:80];
			tick_s1.main_switch_on <= s_tuser[pppc_pkg::SU_MAIN];
			tick_s1.manual_mode    <= s_tuser[pppc_pkg::SU_MANUAL];
			tick_s1.manual_run     <= s_tuser[pppc_pkg::SU_MANRUN];
			tick_s1.lights_enabled <= s_tuser[pppc_pkg::SU_LIGHTS];
		end
	end

	// Error check against the motor state left by the previous tick.
	always_comb begin
		err_next        = error_q;
		motor_after_err = motor_q;
		if (tick_s1.manual_mode) begin
			err_next = 1'b0;
		end else begin
			if ((tick_s1.pressure < pppc_pkg::PRESSURE_LOW) ||
					(tick_s1.pressure > pppc_pkg::PRESSURE_HIGH)) begin
				err_next = 1'b1;
			end
			if (motor_q && (tick_s1.total_current > current_lim_q)) begin
				err_next = 1'b1;
			end
			if (motor_q && (pppc_pkg::phase_spread(tick_s1.phase1_current,
					tick_s1.phase2_current, tick_s1.phase3_current) > imbal_lim_q)) begin
				err_next = 1'b1;
			end
			if (err_next) begin
				motor_after_err = 1'b0;
			end
		end
	end

	// Motor control with hysteresis between the start and stop levels.
	always_comb begin
		motor_next = motor_after_err;
		if (!tick_s1.main_switch_on) begin
			motor_next = 1'b0;
		end else if (tick_s1.manual_mode) begin
			motor_next = tick_s1.manual_run;
		end else if (!err_next) begin
			if (tick_s1.pressure <= pressure_on_q) begin
				motor_next = 1'b1;
			end else if (tick_s1.pressure >= pressure_off_q) begin
				motor_next = 1'b0;
			end
		end
	end

	// Status light levels.
	always_comb begin
		red_d   = pppc_pkg::LEVEL_OFF;
		green_d = pppc_pkg::LEVEL_OFF;
		blue_d  = pppc_pkg::LEVEL_OFF;
		if (tick_s1.lights_enabled) begin
			if (err_next) begin
				red_d = (tick_s1.ms_phase < pppc_pkg::ERROR_BLINK_MS) ?
					pppc_pkg::LEVEL_FULL : pppc_pkg::LEVEL_OFF;
			end else if (!tick_s1.main_switch_on) begin
				red_d = pppc_pkg::LEVEL_FULL;
			end else if (tick_s1.manual_mode) begin
				red_d   = motor_next ? pppc_pkg::LEVEL_OFF : pppc_pkg::LEVEL_FULL;
				green_d = motor_next ? pppc_pkg::LEVEL_OFF : pppc_pkg::LEVEL_DIM;
				blue_d  = motor_next ? pppc_pkg::LEVEL_FULL : pppc_pkg::LEVEL_OFF;
			end else begin
				green_d = (!motor_next && (tick_s1.ms_phase < pppc_pkg::IDLE_BLINK_MS)) ?
					pppc_pkg::LEVEL_FULL : pppc_pkg::LEVEL_OFF;
				blue_d  = motor_next ? pppc_pkg::LEVEL_FULL : pppc_pkg::LEVEL_OFF;
			end
		end
	end

	always_comb begin
		res_d.motor_run   = motor_next;
		res_d.fault       = err_next;
		res_d.red_level   = red_d;
		res_d.green_level = green_d;
		res_d.blue_level  = blue_d;
	end

	// Controller state moves on once per tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			motor_q <= 1'b0;
			error_q <= 1'b0;
		end else if (advance) begin
			motor_q <= motor_next;
			error_q <= err_next;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {res_q.blue_level, res_q.green_level, res_q.red_level};
	assign m_tuser  = {res_q.fault, res_q.motor_run};

	// A latched fault always leaves the motor stopped.
	a_fault_stops_motor: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.fault) |-> !res_q.motor_run)
		else $error("fault reported with motor running");

	// While faulted only the red light may be lit.
	a_fault_lights: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.fault) |->
		(res_q.green_level == pppc_pkg::LEVEL_OFF) && (res_q.blue_level == pppc_pkg::LEVEL_OFF))
		else $error("green or blue lit during fault");

	// The stored state matches the result just produced.
	a_state_tracks_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (motor_q == res_q.motor_run) && (error_q == res_q.fault))
		else $error("controller state differs from issued result");

	// An empty input stage always accepts.
	a_empty_accepts: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_tready)
		else $error("input stage empty but not ready");

endmodule

/* test/tb.sv */
// Self-checking testbench for the pump pressure protection controller top level.
`timescale 1ns / 1ps

module tb;

	localparam int unsigned CYCLE_LIMIT = 400000;

	logic                          clk      = 1'b0;
	logic                          arst_n   = 1'b0;
	logic                          s_tvalid = 1'b0;
	logic                          s_tready;
	logic [pppc_pkg::S_DATAW-1:0]  s_tdata  = '0;
	logic [pppc_pkg::S_USERW-1:0]  s_tuser  = '0;
	logic                          m_tvalid;
	logic                          m_tready = 1'b0;
	logic [pppc_pkg::M_DATAW-1:0]  m_tdata;
	logic [pppc_pkg::M_USERW-1:0]  m_tuser;
	logic                          psel     = 1'b0;
	logic                          penable  = 1'b0;
	logic                          pwrite   = 1'b0;
	logic [pppc_pkg::ADDRW-1:0]    paddr    = '0;
	logic [pppc_pkg::APBW-1:0]     pwdata   = '0;
	logic [pppc_pkg::APBW-1:0]     prdata;
	logic                          pready;

	pump_pressure_protection_controller_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// Free-running clock, 10 ns period.
	always #5 clk = ~clk;

	// Ticks waiting to be sent, and the results they are expected to give.
	pppc_pkg::tick_t   tick_q[$];
	pppc_pkg::result_t status_q[$];
	pppc_pkg::tick_t   cur_tick;
	bit      tick_taken = 1'b0;
	int      gap_pct = 23;
	int      mismatch_count = 0;
	int      cycle_count = 0;

	// Predictor copy of the thresholds and of the motor and fault state.
	int      on_lvl  = int'(pppc_pkg::PRESSURE_ON_RST);
	int      off_lvl = int'(pppc_pkg::PRESSURE_OFF_RST);
	int      cur_lim = int'(pppc_pkg::CURRENT_LIM_RST);
	int      imb_lim = int'(pppc_pkg::IMBAL_LIM_RST);
	bit      pump_running = 1'b0;
	bit      fault_latched = 1'b0;

	task automatic report_mismatch(input string what, input int got, input int want);
		mismatch_count++;
		$display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
	endtask

	// Works out the result of one tick and advances the motor and fault state.
	function automatic pppc_pkg::result_t predict_tick(input pppc_pkg::tick_t t);
		pppc_pkg::result_t       r;
		logic [pppc_pkg::QW-1:0] hi;
		logic [pppc_pkg::QW-1:0] lo;
		hi = (t.phase1_current > t.phase2_current) ? t.phase1_current : t.phase2_current;
		hi = (hi > t.phase3_current) ? hi : t.phase3_current;
		lo = (t.phase1_current < t.phase2_current) ? t.phase1_current : t.phase2_current;
		lo = (lo < t.phase3_current) ? lo : t.phase3_current;

		// Fault check against the motor state left by the previous tick.
		if (t.manual_mode) begin
			fault_latched = 1'b0;
		end else begin
			if (t.pressure < pppc_pkg::PRESSURE_LOW || t.pressure > pppc_pkg::PRESSURE_HIGH)
				fault_latched = 1'b1;
			if (pump_running && t.total_current > cur_lim)
				fault_latched = 1'b1;
			if (pump_running && (hi - lo) > imb_lim)
				fault_latched = 1'b1;
			if (fault_latched)
				pump_running = 1'b0;
		end

		// Motor control with hysteresis in automatic mode.
		if (!t.main_switch_on) begin
			pump_running = 1'b0;
		end else if (t.manual_mode) begin
			pump_running = t.manual_run;
		end else if (!fault_latched) begin
			if (t.pressure <= on_lvl)
				pump_running = 1'b1;
			else if (t.pressure >= off_lvl)
				pump_running = 1'b0;
		end

		// Status lights.
		r.red_level   = pppc_pkg::LEVEL_OFF;
		r.green_level = pppc_pkg::LEVEL_OFF;
		r.blue_level  = pppc_pkg::LEVEL_OFF;
		if (t.lights_enabled) begin
			if (fault_latched) begin
				r.red_level = (t.ms_phase < pppc_pkg::ERROR_BLINK_MS) ?
						pppc_pkg::LEVEL_FULL : pppc_pkg::LEVEL_OFF;
			end else if (!t.main_switch_on) begin
				r.red_level = pppc_pkg::LEVEL_FULL;
			end else if (t.manual_mode) begin
				r.red_level   = pump_running ? pppc_pkg::LEVEL_OFF : pppc_pkg::LEVEL_FULL;
				r.green_level = pump_running ? pppc_pkg::LEVEL_OFF : pppc_pkg::LEVEL_DIM;
				r.blue_level  = pump_running ? pppc_pkg::LEVEL_FULL : pppc_pkg::LEVEL_OFF;
			end else begin
				r.green_level = (!pump_running && t.ms_phase < pppc_pkg::IDLE_BLINK_MS) ?
						pppc_pkg::LEVEL_FULL : pppc_pkg::LEVEL_OFF;
				r.blue_level  = pump_running ? pppc_pkg::LEVEL_FULL : pppc_pkg::LEVEL_OFF;
			end
		end
		r.motor_run = pump_running;
		r.fault     = fault_latched;
		return r;
	endfunction

	function automatic int clip16(input int v);
		return (v < 0) ? 0 : ((v > 65535) ? 65535 : v);
	endfunction

	function automatic int near_val(input int centre, input int span);
		return clip16(centre + int'($urandom_range(0, 2 * span)) - span);
	endfunction

	// Random tick, weighted towards the thresholds so that the hysteresis and the
	// fault checks are reached often, with a share of full-range values.
	function automatic pppc_pkg::tick_t rand_tick();
		pppc_pkg::tick_t t;
		int    sel;
		int    base;
		int    d;
		int    a;
		int    b;
		int    c;
		sel = $urandom_range(0, 99);
		if (sel < 35)
			t.pressure = 16'(near_val(on_lvl, 24));
		else if (sel < 62)
			t.pressure = 16'(near_val(off_lvl, 24));
		else if (sel < 85)
			t.pressure = 16'($urandom_range(pppc_pkg::PRESSURE_LOW, pppc_pkg::PRESSURE_HIGH));
		else if (sel < 93)
			t.pressure = $urandom_range(0, 1) ?
					16'(near_val(int'(pppc_pkg::PRESSURE_LOW), 4)) :
					16'(near_val(int'(pppc_pkg::PRESSURE_HIGH), 4));
		else if (sel < 98)
			t.pressure = 16'($urandom_range(0, 65535));
		else
			t.pressure = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;

		sel = $urandom_range(0, 99);
		if (sel < 20)
			t.total_current = 16'(near_val(cur_lim, 6));
		else if (sel < 85)
			t.total_current = 16'($urandom_range(0, cur_lim));
		else
			t.total_current = 16'($urandom_range(0, 65535));

		base = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535) :
				$urandom_range(0, 30000);
		sel = $urandom_range(0, 99);
		if (sel < 60)
			d = $urandom_range(0, imb_lim);
		else if (sel < 85)
			d = near_val(imb_lim, 4);
		else
			d = $urandom_range(0, 65535);
		a = base;
		b = clip16(base + d);
		c = clip16(base + int'($urandom_range(0, d)));
		case ($urandom_range(0, 2))
			0: begin
				t.phase1_current = 16'(a); t.phase2_current = 16'(b); t.phase3_current = 16'(c);
			end
			1: begin
				t.phase1_current = 16'(b); t.phase2_current = 16'(c); t.phase3_current = 16'(a);
			end
			default: begin
				t.phase1_current = 16'(c); t.phase2_current = 16'(a); t.phase3_current = 16'(b);
			end
		endcase

		t.main_switch_on = ($urandom_range(0, 99) < 90);
		t.manual_mode    = ($urandom_range(0, 99) < 15);
		t.manual_run     = 1'($urandom_range(0, 1));
		t.lights_enabled = ($urandom_range(0, 99) < 85);
		t.ms_phase       = 10'($urandom_range(0, 1023));
		return t;
	endfunction

	task automatic add_tick(input int p, input int itot, input int i1, input int i2,
			input int i3, input bit main_on, input bit manual, input bit run,
			input bit lights, input int ms);
		pppc_pkg::tick_t t;
		t.pressure       = 16'(p);
		t.total_current  = 16'(itot);
		t.phase1_current = 16'(i1);
		t.phase2_current = 16'(i2);
		t.phase3_current = 16'(i3);
		t.main_switch_on = main_on;
		t.manual_mode    = manual;
		t.manual_run     = run;
		t.lights_enabled = lights;
		t.ms_phase       = 10'(ms);
		tick_q.push_back(t);
	endtask

	// APB write: setup cycle, then access cycle; the register takes the value at the
	// rising edge inside the access cycle.
	task automatic write_reg(input logic [1:0] idx, input int val);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {16'($urandom_range(0, 65535)), 16'(val)};
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			pppc_pkg::REG_PRESSURE_ON:  on_lvl  = val;
			pppc_pkg::REG_PRESSURE_OFF: off_lvl = val;
			pppc_pkg::REG_CURRENT_LIM:  cur_lim = val;
			default:                    imb_lim = val;
		endcase
	endtask

	// Waits until every tick has been sent and every result has come back.
	task automatic wait_drained();
		while (tick_q.size() != 0 || s_tvalid || status_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Thresholds change only once the block is empty.
	task automatic run_phase(input int on_v, input int off_v, input int cur_v,
			input int imb_v, input int n);
		wait_drained();
		write_reg(pppc_pkg::REG_PRESSURE_ON, on_v);
		write_reg(pppc_pkg::REG_PRESSURE_OFF, off_v);
		write_reg(pppc_pkg::REG_CURRENT_LIM, cur_v);
		write_reg(pppc_pkg::REG_IMBAL_LIM, imb_v);
		repeat (n) tick_q.push_back(rand_tick());
		wait_drained();
	endtask

	// Input driver: presents the next tick after each accepted beat, with random gaps.
	always @(negedge clk) begin
		if (!s_tvalid || tick_taken) begin
			if (tick_q.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
				cur_tick <= tick_q[0];
				s_tdata  <= {6'b0, tick_q[0].ms_phase, tick_q[0].phase3_current,
						tick_q[0].phase2_current, tick_q[0].phase1_current,
						tick_q[0].total_current, tick_q[0].pressure};
				s_tuser  <= {tick_q[0].lights_enabled, tick_q[0].manual_run,
						tick_q[0].manual_mode, tick_q[0].main_switch_on};
				s_tvalid <= 1'b1;
				void'(tick_q.pop_front());
			end else begin
				s_tvalid <= 1'b0;
			end
		end
		m_tready <= ($urandom_range(0, 99) >= gap_pct);
	end

	// Monitor: checks each output beat and predicts each accepted input beat.
	always @(posedge clk) begin
		pppc_pkg::result_t want;
		tick_taken = 1'b0;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (status_q.size() == 0) begin
					report_mismatch("unexpected result beat, tdata", m_tdata, 0);
				end else begin
					want = status_q.pop_front();
					if (m_tuser[pppc_pkg::MU_MOTOR] !== want.motor_run)
						report_mismatch("motor_run", m_tuser[pppc_pkg::MU_MOTOR],
								want.motor_run);
					if (m_tuser[pppc_pkg::MU_FAULT] !== want.fault)
						report_mismatch("fault", m_tuser[pppc_pkg::MU_FAULT], want.fault);
					if (m_tdata[7:0] !== want.red_level)
						report_mismatch("red_level", m_tdata[7:0], want.red_level);
					if (m_tdata[15:8] !== want.green_level)
						report_mismatch("green_level", m_tdata[15:8], want.green_level);
					if (m_tdata[23:16] !== want.blue_level)
						report_mismatch("blue_level", m_tdata[23:16], want.blue_level);
				end
			end
			if (s_tvalid && s_tready) begin
				status_q.push_back(predict_tick(cur_tick));
				tick_taken = 1'b1;
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed ticks at the reset thresholds: hysteresis edges, limits, blink
		// phases, override, main switch off, lights off and pressure window edges.
		add_tick(600, 0, 100, 100, 100, 1, 0, 0, 1, 10);
		add_tick(700, 3840, 100, 868, 500, 1, 0, 0, 1, 0);
		add_tick(900, 0, 0, 0, 0, 1, 0, 0, 1, 20);
		add_tick(640, 0, 0, 0, 0, 1, 0, 0, 1, 49);
		add_tick(800, 3841, 0, 0, 0, 1, 0, 0, 1, 499);
		add_tick(800, 0, 0, 0, 0, 1, 0, 0, 1, 500);
		add_tick(800, 0, 0, 0, 0, 1, 1, 0, 1, 1000);
		add_tick(0, 65535, 0, 65535, 0, 1, 1, 1, 1, 30);
		add_tick(640, 0, 1000, 231, 1000, 1, 0, 0, 1, 100);
		add_tick(700, 0, 0, 0, 0, 1, 1, 1, 0, 10);
		add_tick(700, 0, 0, 0, 0, 0, 0, 0, 1, 10);
		add_tick(255, 0, 0, 0, 0, 1, 0, 0, 1, 1023);
		add_tick(255, 0, 0, 0, 0, 1, 1, 0, 1, 999);
		add_tick(256, 0, 0, 0, 0, 1, 0, 0, 1, 50);
		add_tick(1280, 0, 0, 0, 0, 1, 0, 0, 1, 0);
		add_tick(1281, 0, 0, 0, 0, 1, 0, 0, 1, 0);
		add_tick(65535, 0, 0, 0, 0, 1, 1, 0, 1, 999);
		add_tick(65535, 0, 0, 0, 0, 1, 0, 0, 1, 600);
		add_tick(1000, 65535, 65535, 65535, 65535, 1, 1, 1, 1, 1023);
		add_tick(1000, 65535, 65535, 65535, 65535, 1, 0, 0, 1, 200);
		add_tick(896, 0, 0, 0, 0, 1, 1, 0, 1, 0);
		add_tick(641, 0, 0, 0, 0, 1, 0, 1, 1, 0);
		add_tick(896, 0, 0, 0, 0, 0, 1, 1, 0, 0);
		run_phase(int'(pppc_pkg::PRESSURE_ON_RST), int'(pppc_pkg::PRESSURE_OFF_RST),
				int'(pppc_pkg::CURRENT_LIM_RST), int'(pppc_pkg::IMBAL_LIM_RST), 250);

		// Extremes of the thresholds; the all-ones setting runs without any gaps.
		run_phase(0, 0, 0, 0, 120);
		gap_pct = 0;
		run_phase(65535, 65535, 65535, 65535, 120);
		gap_pct = 23;

		// Start level above stop level.
		run_phase(1200, 300, 1000, 100, 200);

		// Random thresholds, then a realistic random setting.
		run_phase($urandom_range(0, 65535), $urandom_range(0, 65535),
				$urandom_range(0, 65535), $urandom_range(0, 65535), 230);
		begin
			int lo_v;
			lo_v = $urandom_range(300, 800);
			run_phase(lo_v, lo_v + $urandom_range(10, 400), $urandom_range(1000, 8000),
					$urandom_range(50, 1500), 230);
		end

		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
